/* design/m6502_pkg.sv */
// ----------------------------------------------------------------------------
// m6502_pkg
// shared types, codes and decode functions of the 6502 instruction core
// ----------------------------------------------------------------------------
package m6502_pkg;

  localparam logic [3:0] M_IMM = 4'd0;
  localparam logic [3:0] M_ZP  = 4'd1;
  localparam logic [3:0] M_ZPX = 4'd2;
  localparam logic [3:0] M_ZPY = 4'd3;
  localparam logic [3:0] M_ABS = 4'd4;
  localparam logic [3:0] M_ABX = 4'd5;
  localparam logic [3:0] M_ABY = 4'd6;
  localparam logic [3:0] M_INX = 4'd7;
  localparam logic [3:0] M_INY = 4'd8;
  localparam logic [3:0] M_REL = 4'd9;
  localparam logic [3:0] M_IND = 4'd10;

  localparam logic [4:0] O_ORA = 5'd0;
  localparam logic [4:0] O_AND = 5'd1;
  localparam logic [4:0] O_EOR = 5'd2;
  localparam logic [4:0] O_ADC = 5'd3;
  localparam logic [4:0] O_STA = 5'd4;
  localparam logic [4:0] O_LDA = 5'd5;
  localparam logic [4:0] O_CMP = 5'd6;
  localparam logic [4:0] O_SBC = 5'd7;
  localparam logic [4:0] O_ASL = 5'd8;
  localparam logic [4:0] O_ROL = 5'd9;
  localparam logic [4:0] O_LSR = 5'd10;
  localparam logic [4:0] O_ROR = 5'd11;
  localparam logic [4:0] O_STX = 5'd12;
  localparam logic [4:0] O_LDX = 5'd13;
  localparam logic [4:0] O_DEC = 5'd14;
  localparam logic [4:0] O_INC = 5'd15;
  localparam logic [4:0] O_BIT = 5'd16;
  localparam logic [4:0] O_STY = 5'd17;
  localparam logic [4:0] O_LDY = 5'd18;
  localparam logic [4:0] O_CPY = 5'd19;
  localparam logic [4:0] O_CPX = 5'd20;
  localparam logic [4:0] O_JMP = 5'd21;
  localparam logic [4:0] O_JSR = 5'd22;
  localparam logic [4:0] O_BR  = 5'd23;

  localparam logic [7:0] F_C = 8'h01;
  localparam logic [7:0] F_Z = 8'h02;
  localparam logic [7:0] F_I = 8'h04;
  localparam logic [7:0] F_D = 8'h08;
  localparam logic [7:0] F_B = 8'h10;
  localparam logic [7:0] F_V = 8'h40;

  localparam logic [15:0] VEC_RESET = 16'hFFFC;
  localparam logic [15:0] VEC_BRK   = 16'hFFFE;
  localparam logic [7:0]  STACK_PG  = 8'h01;
  localparam logic [7:0]  SP_RESET  = 8'hFF;

  localparam logic [7:0] OPC_BRK = 8'h00;
  localparam logic [7:0] OPC_PHP = 8'h08;
  localparam logic [7:0] OPC_PLP = 8'h28;
  localparam logic [7:0] OPC_RTI = 8'h40;
  localparam logic [7:0] OPC_PHA = 8'h48;
  localparam logic [7:0] OPC_RTS = 8'h60;
  localparam logic [7:0] OPC_PLA = 8'h68;

  typedef struct packed {
    logic        bus_write;
    logic [15:0] bus_addr;
    logic [7:0]  bus_wdata;
    logic        instr_done;
    logic [2:0]  instr_cycles;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [2:0]       cnt;
    res_t [3:0]       res;
  } grp_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] mode;
    logic [4:0] op;
  } dec_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } regs_t;

  typedef struct packed {
    logic       hit;
    regs_t      regs;
  } impl_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] p;
  } mod_t;

  function automatic res_t mk_res(logic wr, logic [15:0] addr, logic [7:0] wd,
                                  logic [2:0] cyc);
    res_t r;
    r.bus_write    = wr;
    r.bus_addr     = addr;
    r.bus_wdata    = wr ? wd : 8'h00;
    r.instr_done   = (cyc != 3'd0);
    r.instr_cycles = cyc;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] set_nz(logic [7:0] p, logic [7:0] v);
    return (p & 8'h7D) | (v & 8'h80) | ((v == 8'h00) ? F_Z : 8'h00);
  endfunction

  function automatic mod_t modify(logic [4:0] op, logic [7:0] v, logic [7:0] p);
    mod_t m;
    logic c;
    c = p[0];
    case (op)
      O_ASL:   begin c = v[7]; m.r = {v[6:0], 1'b0}; end
      O_ROL:   begin m.r = {v[6:0], p[0]}; c = v[7]; end
      O_LSR:   begin c = v[0]; m.r = {1'b0, v[7:1]}; end
      O_ROR:   begin m.r = {p[0], v[7:1]}; c = v[0]; end
      O_DEC:   m.r = v - 8'd1;
      default: m.r = v + 8'd1;
    endcase
    m.p = set_nz({p[7:1], c}, m.r);
    return m;
  endfunction

  function automatic regs_t alu(logic [4:0] op, logic [7:0] v, regs_t g);
    regs_t o;
    logic [8:0] s;
    logic [7:0] w;
    logic [7:0] cr;
    o = g;
    w = (op == O_SBC) ? ~v : v;
    s = {1'b0, g.a} + {1'b0, w} + {8'h00, g.p[0]};
    cr = g.a;
    if (op == O_CPY) cr = g.y;
    if (op == O_CPX) cr = g.x;
    case (op)
      O_ORA: begin o.a = g.a | v; o.p = set_nz(g.p, o.a); end
      O_AND: begin o.a = g.a & v; o.p = set_nz(g.p, o.a); end
      O_EOR: begin o.a = g.a ^ v; o.p = set_nz(g.p, o.a); end
      O_ADC, O_SBC: begin
        o.a = s[7:0];
        o.p = (g.p & 8'hBE) | (s[8] ? F_C : 8'h00) |
              ((~(g.a ^ w) & (g.a ^ s[7:0]) & 8'h80) != 8'h00 ? F_V : 8'h00);
        o.p = set_nz(o.p, s[7:0]);
      end
      O_LDA: begin o.a = v; o.p = set_nz(g.p, v); end
      O_LDX: begin o.x = v; o.p = set_nz(g.p, v); end
      O_LDY: begin o.y = v; o.p = set_nz(g.p, v); end
      O_CMP, O_CPX, O_CPY:
        o.p = set_nz((g.p & 8'hFE) | ((cr >= v) ? F_C : 8'h00), cr - v);
      O_BIT:
        o.p = (g.p & 8'h3D) | (v & 8'hC0) | (((g.a & v) == 8'h00) ? F_Z : 8'h00);
      default: o = g;
    endcase
    return o;
  endfunction

  function automatic logic [3:0] g1_mode(logic [2:0] bbb);
    logic [3:0] m;
    unique case (bbb)
      3'd0: m = M_INX;
      3'd1: m = M_ZP;
      3'd2: m = M_IMM;
      3'd3: m = M_ABS;
      3'd4: m = M_INY;
      3'd5: m = M_ZPX;
      3'd6: m = M_ABY;
      default: m = M_ABX;
    endcase
    return m;
  endfunction

  function automatic dec_t decode(logic [7:0] opc);
    dec_t r;
    logic [2:0] aaa;
    logic [2:0] bbb;
    logic xy;
    r = '0;
    aaa = opc[7:5];
    bbb = opc[4:2];
    xy = (aaa == 3'd4) || (aaa == 3'd5);
    if (opc == 8'h20) begin
      r = '{1'b1, M_ABS, O_JSR};
    end else if (opc == 8'h4C) begin
      r = '{1'b1, M_ABS, O_JMP};
    end else if (opc == 8'h6C) begin
      r = '{1'b1, M_IND, O_JMP};
    end else if (opc[4:0] == 5'h10) begin
      r = '{1'b1, M_REL, O_BR};
    end else if (opc[1:0] == 2'd1) begin
      if (opc != 8'h89) r = '{1'b1, g1_mode(bbb), {2'b00, aaa}};
    end else if (opc[1:0] == 2'd2) begin
      r.op = 5'd8 + {2'b00, aaa};
      unique case (bbb)
        3'd0: begin r.valid = (opc == 8'hA2); r.mode = M_IMM; end
        3'd1: begin r.valid = 1'b1; r.mode = M_ZP; end
        3'd3: begin r.valid = 1'b1; r.mode = M_ABS; end
        3'd5: begin r.valid = 1'b1; r.mode = xy ? M_ZPY : M_ZPX; end
        3'd7: begin r.valid = (opc != 8'h9E); r.mode = xy ? M_ABY : M_ABX; end
        default: r.valid = 1'b0;
      endcase
    end else if (opc[1:0] == 2'd0) begin
      unique case (opc)
        8'h24: r = '{1'b1, M_ZP,  O_BIT};
        8'h2C: r = '{1'b1, M_ABS, O_BIT};
        8'h84: r = '{1'b1, M_ZP,  O_STY};
        8'h8C: r = '{1'b1, M_ABS, O_STY};
        8'h94: r = '{1'b1, M_ZPX, O_STY};
        8'hA0: r = '{1'b1, M_IMM, O_LDY};
        8'hA4: r = '{1'b1, M_ZP,  O_LDY};
        8'hAC: r = '{1'b1, M_ABS, O_LDY};
        8'hB4: r = '{1'b1, M_ZPX, O_LDY};
        8'hBC: r = '{1'b1, M_ABX, O_LDY};
        8'hC0: r = '{1'b1, M_IMM, O_CPY};
        8'hC4: r = '{1'b1, M_ZP,  O_CPY};
        8'hCC: r = '{1'b1, M_ABS, O_CPY};
        8'hE0: r = '{1'b1, M_IMM, O_CPX};
        8'hE4: r = '{1'b1, M_ZP,  O_CPX};
        8'hEC: r = '{1'b1, M_ABS, O_CPX};
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic logic is_store(logic [4:0] op);
    return (op == O_STA) || (op == O_STX) || (op == O_STY);
  endfunction

  function automatic logic is_rmw(logic [4:0] op);
    return (op >= O_ASL && op <= O_ROR) || (op == O_DEC) || (op == O_INC);
  endfunction

  function automatic logic [2:0] cycles_of(logic [3:0] mode, logic [4:0] op,
                                           logic pcx);
    logic [2:0] c;
    c = 3'd2;
    if (is_store(op)) begin
      case (mode)
        M_ZP: c = 3'd3;
        M_ZPX, M_ZPY, M_ABS: c = 3'd4;
        M_ABX, M_ABY: c = 3'd5;
        M_INX, M_INY: c = 3'd6;
        default: c = 3'd2;
      endcase
    end else if (is_rmw(op)) begin
      case (mode)
        M_ZP: c = 3'd5;
        M_ZPX, M_ZPY, M_ABS: c = 3'd6;
        M_ABX, M_ABY, M_INX, M_INY: c = 3'd7;
        default: c = 3'd2;
      endcase
    end else begin
      case (mode)
        M_ZP: c = 3'd3;
        M_ZPX, M_ZPY, M_ABS: c = 3'd4;
        M_ABX, M_ABY: c = 3'd4 + {2'b00, pcx};
        M_INX: c = 3'd6;
        M_INY: c = 3'd5 + {2'b00, pcx};
        default: c = 3'd2;
      endcase
    end
    return c;
  endfunction

  function automatic logic [2:0] dop_cycles(logic [7:0] opc);
    logic [2:0] c;
    case (opc)
      8'h80, 8'h82, 8'h89, 8'hC2, 8'hE2: c = 3'd2;
      8'h04, 8'h44, 8'h64: c = 3'd3;
      8'h14, 8'h34, 8'h54, 8'h74, 8'hD4, 8'hF4: c = 3'd4;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic impl_t implied(logic [7:0] opc, regs_t g);
    impl_t o;
    mod_t m;
    o.hit = 1'b1;
    o.regs = g;
    m = modify(5'd8 + {2'b00, opc[7:5]}, g.a, g.p);
    case (opc)
      8'h18: o.regs.p = g.p & 8'hFE;
      8'h38: o.regs.p = g.p | F_C;
      8'h58: o.regs.p = g.p & 8'hFB;
      8'h78: o.regs.p = g.p | F_I;
      8'hB8: o.regs.p = g.p & 8'hBF;
      8'hD8: o.regs.p = g.p & 8'hF7;
      8'hF8: o.regs.p = g.p | F_D;
      8'hCA: begin o.regs.x = g.x - 8'd1; o.regs.p = set_nz(g.p, o.regs.x); end
      8'h88: begin o.regs.y = g.y - 8'd1; o.regs.p = set_nz(g.p, o.regs.y); end
      8'hE8: begin o.regs.x = g.x + 8'd1; o.regs.p = set_nz(g.p, o.regs.x); end
      8'hC8: begin o.regs.y = g.y + 8'd1; o.regs.p = set_nz(g.p, o.regs.y); end
      8'hAA: begin o.regs.x = g.a; o.regs.p = set_nz(g.p, g.a); end
      8'hA8: begin o.regs.y = g.a; o.regs.p = set_nz(g.p, g.a); end
      8'hBA: begin o.regs.x = g.sp; o.regs.p = set_nz(g.p, g.sp); end
      8'h8A: begin o.regs.a = g.x; o.regs.p = set_nz(g.p, g.x); end
      8'h98: begin o.regs.a = g.y; o.regs.p = set_nz(g.p, g.y); end
      8'h9A: o.regs.sp = g.x;
      8'h0A, 8'h2A, 8'h4A, 8'h6A: begin o.regs.a = m.r; o.regs.p = m.p; end
      8'hEA: o.hit = 1'b1;
      default: o.hit = 1'b0;
    endcase
    return o;
  endfunction

endpackage

/* design/m6502_if.sv */
// ----------------------------------------------------------------------------
// m6502 channel interfaces
// valid/ready channels for returned read data and for bus requests
// ----------------------------------------------------------------------------
interface m6502_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] read_data;

  modport source (output valid, output cmd, output read_data, input ready);
  modport sink (input valid, input cmd, input read_data, output ready);
endinterface

interface m6502_out_if;
  logic        valid;
  logic        ready;
  logic        bus_write;
  logic [15:0] bus_addr;
  logic [7:0]  bus_wdata;
  logic        instr_done;
  logic [2:0]  instr_cycles;
  logic        last;

  modport source (output valid, output bus_write, output bus_addr, output bus_wdata,
                  output instr_done, output instr_cycles, output last, input ready);
  modport sink (input valid, input bus_write, input bus_addr, input bus_wdata,
                input instr_done, input instr_cycles, input last, output ready);
endinterface

/* design/mos6502_instruction_core_top.sv */
// ----------------------------------------------------------------------------
// mos6502_instruction_core_top
// binary-mode 6502 core stepped one returned bus byte at a time
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | beat
//  in_i    | in  | cmd, read_data                           | one returned byte
//  out_o   | out | bus_write, bus_addr, bus_wdata,          | one bus request
//          |     | instr_done, instr_cycles, last           |
//
//  an input beat's 0 to 4 requests are registered together as one group
//  (a beat with none pushes nothing); they leave at one per cycle while
//  the receiver is ready; a two-group buffer keeps input open while the
//  output is stalled, until it holds two groups
//  rst_ni resets state (sp to FF); the core then idles until cmd 0
// ----------------------------------------------------------------------------
module mos6502_instruction_core_top import m6502_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  m6502_in_if.sink     in_i,
  m6502_out_if.source  out_o
);

  grp_t grp;
  res_t res;
  logic q_ready;
  logic in_beat;
  logic out_beat;

  assign in_i.ready = q_ready;
  assign in_beat    = in_i.valid & q_ready;
  assign out_beat   = out_o.valid & out_o.ready;

  m6502_exec u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (in_beat),
    .cmd_i   (in_i.cmd),
    .rdata_i (in_i.read_data),
    .grp_o   (grp)
  );

  m6502_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_beat && grp.cnt != 3'd0),
    .grp_i   (grp),
    .ready_o (q_ready),
    .valid_o (out_o.valid),
    .pop_i   (out_beat),
    .res_o   (res)
  );

  assign out_o.bus_write    = res.bus_write;
  assign out_o.bus_addr     = res.bus_addr;
  assign out_o.bus_wdata    = res.bus_wdata;
  assign out_o.instr_done   = res.instr_done;
  assign out_o.instr_cycles = res.instr_cycles;
  assign out_o.last         = res.last;

`ifndef SYNTHESIS
  a_cyc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.instr_done || out_o.instr_cycles == 3'd0))
    else $error("cycle count without completed instruction");

  a_write_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bus_write |-> !out_o.last)
    else $error("write request closes a group");

  a_done_is_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.instr_done |-> !out_o.bus_write && out_o.last)
    else $error("completion marked on a non-fetch request");

  a_cmd0_reads_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && !in_i.cmd |-> grp.cnt == 3'd1 && grp.res[0].bus_addr == VEC_RESET)
    else $error("reset beat did not request the vector");
`endif

endmodule

/* design/m6502_exec.sv */
// ----------------------------------------------------------------------------
// m6502_exec
// architectural registers and bus sequencer; one input beat per step
// ----------------------------------------------------------------------------
module m6502_exec import m6502_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic       cmd_i,
  input  logic [7:0] rdata_i,
  output grp_t       grp_o
);

  typedef enum logic [3:0] {
    P_IDLE, P_VLO, P_VHI, P_FETCH, P_OP1, P_OP2, P_PTR1, P_PTR2, P_DATA,
    P_PULL1, P_PULL2, P_PULL3
  } phase_e;

  phase_e      ph_q, ph_d;
  regs_t       g_q, g_d;
  logic [15:0] pc_q, pc_d;
  logic [7:0]  opc_q, opc_d;
  logic [15:0] oa_q, oa_d;
  logic [7:0]  plo_q, plo_d;
  logic        pcx_q, pcx_d;

  always_comb begin
    grp_t       r;
    logic [2:0] n;
    logic [7:0] d;
    logic [15:0] pc1;
    logic [15:0] base;
    logic [15:0] tgt;
    logic [8:0]  lo;
    logic [7:0]  idx;
    logic [2:0]  dc;
    logic        exec_en;
    logic        acc_en;
    logic        taken;
    dec_t        dec;
    dec_t        dec_nx;
    impl_t       im;
    mod_t        m;

    r = '0;
    n = 3'd0;
    d = rdata_i;
    ph_d = ph_q; g_d = g_q; pc_d = pc_q; opc_d = opc_q;
    oa_d = oa_q; plo_d = plo_q; pcx_d = pcx_q;
    exec_en = 1'b0;
    acc_en = 1'b0;
    pc1 = pc_q + 16'd1;
    dec = decode(opc_q);
    dec_nx = decode(d);
    im = implied(d, g_q);
    dc = dop_cycles(d);
    base = {d, oa_q[7:0]};
    tgt = pc1 + {{8{d[7]}}, d};
    lo = '0;
    idx = (dec.mode == M_ABY || dec.mode == M_INY) ? g_q.y : g_q.x;
    taken = 1'b0;
    m = '0;

    if (!cmd_i) begin
      g_d.sp = SP_RESET;
      oa_d = VEC_RESET;
      r.res[n[1:0]] = mk_res(1'b0, VEC_RESET, 8'h00, 3'd0); n = n + 3'd1;
      ph_d = P_VLO;
    end else begin
      unique case (ph_q)
        P_VLO: begin
          pc_d = {8'h00, d};
          r.res[n[1:0]] = mk_res(1'b0, oa_q + 16'd1, 8'h00, 3'd0); n = n + 3'd1;
          ph_d = P_VHI;
        end
        P_VHI: begin
          pc_d = {d, pc_q[7:0]};
          r.res[n[1:0]] = mk_res(1'b0, pc_d, 8'h00, (oa_q == VEC_BRK) ? 3'd7 : 3'd0);
          n = n + 3'd1;
          ph_d = P_FETCH;
        end
        P_FETCH: begin
          opc_d = d;
          pc_d = pc1;
          ph_d = P_FETCH;
          if (im.hit) begin
            g_d = im.regs;
            r.res[n[1:0]] = mk_res(1'b0, pc1, 8'h00, 3'd2); n = n + 3'd1;
          end else if (dc != 3'd0) begin
            pc_d = pc1 + 16'd1;
            r.res[n[1:0]] = mk_res(1'b0, pc_d, 8'h00, dc); n = n + 3'd1;
          end else if (d == OPC_BRK) begin
            pc_d = pc1 + 16'd1;
            r.res[n[1:0]] = mk_res(1'b1, {STACK_PG, g_q.sp}, pc_d[15:8], 3'd0);
            n = n + 3'd1;
            r.res[n[1:0]] = mk_res(1'b1, {STACK_PG, g_q.sp - 8'd1}, pc_d[7:0], 3'd0);
            n = n + 3'd1;
            r.res[n[1:0]] = mk_res(1'b1, {STACK_PG, g_q.sp - 8'd2}, g_q.p | 8'h30, 3'd0);
            n = n + 3'd1;
            g_d.sp = g_q.sp - 8'd3;
            g_d.p = g_q.p | F_I | F_B;
            oa_d = VEC_BRK;
            r.res[n[1:0]] = mk_res(1'b0, VEC_BRK, 8'h00, 3'd0); n = n + 3'd1;
            ph_d = P_VLO;
          end else if (d == OPC_PHA || d == OPC_PHP) begin
            r.res[n[1:0]] = mk_res(1'b1, {STACK_PG, g_q.sp},
                                   (d == OPC_PHA) ? g_q.a : (g_q.p | 8'h30), 3'd0);
            n = n + 3'd1;
            g_d.sp = g_q.sp - 8'd1;
            r.res[n[1:0]] = mk_res(1'b0, pc1, 8'h00, 3'd3); n = n + 3'd1;
          end else if (d == OPC_PLA || d == OPC_PLP || d == OPC_RTS || d == OPC_RTI) begin
            g_d.sp = g_q.sp + 8'd1;
            r.res[n[1:0]] = mk_res(1'b0, {STACK_PG, g_d.sp}, 8'h00, 3'd0); n = n + 3'd1;
            ph_d = P_PULL1;
          end else if (dec_nx.valid) begin
            r.res[n[1:0]] = mk_res(1'b0, pc1, 8'h00, 3'd0); n = n + 3'd1;
            ph_d = P_OP1;
          end else begin
            r.res[n[1:0]] = mk_res(1'b0, pc1, 8'h00, 3'd2); n = n + 3'd1;
          end
        end
        P_OP1: begin
          pc_d = pc1;
          case (dec.mode)
            M_IMM: exec_en = 1'b1;
            M_ZP: begin oa_d = {8'h00, d}; acc_en = 1'b1; end
            M_ZPX: begin oa_d = {8'h00, d + g_q.x}; acc_en = 1'b1; end
            M_ZPY: begin oa_d = {8'h00, d + g_q.y}; acc_en = 1'b1; end
            M_INX, M_INY: begin
              oa_d = {8'h00, (dec.mode == M_INX) ? d + g_q.x : d};
              r.res[n[1:0]] = mk_res(1'b0, oa_d, 8'h00, 3'd0); n = n + 3'd1;
              ph_d = P_PTR1;
            end
            M_REL: begin
              case (opc_q[7:6])
                2'd0: taken = g_q.p[7];
                2'd1: taken = g_q.p[6];
                2'd2: taken = g_q.p[0];
                default: taken = g_q.p[1];
              endcase
              if (taken == opc_q[5]) begin
                pc_d = tgt;
                r.res[n[1:0]] = mk_res(1'b0, tgt, 8'h00,
                                       (tgt[15:8] != pc1[15:8]) ? 3'd4 : 3'd3);
              end else begin
                r.res[n[1:0]] = mk_res(1'b0, pc1, 8'h00, 3'd2);
              end
              n = n + 3'd1;
              ph_d = P_FETCH;
            end
            default: begin
              oa_d = {8'h00, d};
              r.res[n[1:0]] = mk_res(1'b0, pc1, 8'h00, 3'd0); n = n + 3'd1;
              ph_d = P_OP2;
            end
          endcase
        end
        P_OP2: begin
          pc_d = pc1;
          if (dec.mode == M_IND) begin
            oa_d = base;
            r.res[n[1:0]] = mk_res(1'b0, base, 8'h00, 3'd0); n = n + 3'd1;
            ph_d = P_PTR1;
          end else if (dec.op == O_JMP) begin
            pc_d = base;
            r.res[n[1:0]] = mk_res(1'b0, base, 8'h00, 3'd3); n = n + 3'd1;
            ph_d = P_FETCH;
          end else if (dec.op == O_JSR) begin
            r.res[n[1:0]] = mk_res(1'b1, {STACK_PG, g_q.sp}, pc_q[15:8], 3'd0);
            n = n + 3'd1;
            r.res[n[1:0]] = mk_res(1'b1, {STACK_PG, g_q.sp - 8'd1}, pc_q[7:0], 3'd0);
            n = n + 3'd1;
            g_d.sp = g_q.sp - 8'd2;
            pc_d = base;
            r.res[n[1:0]] = mk_res(1'b0, base, 8'h00, 3'd6); n = n + 3'd1;
            ph_d = P_FETCH;
          end else begin
            if (dec.mode == M_ABX || dec.mode == M_ABY) begin
              lo = {1'b0, base[7:0]} + {1'b0, idx};
              pcx_d = lo[8];
              oa_d = base + {8'h00, idx};
            end else begin
              oa_d = base;
            end
            acc_en = 1'b1;
          end
        end
        P_PTR1: begin
          plo_d = d;
          r.res[n[1:0]] = mk_res(1'b0, {oa_q[15:8], oa_q[7:0] + 8'd1}, 8'h00, 3'd0);
          n = n + 3'd1;
          ph_d = P_PTR2;
        end
        P_PTR2: begin
          if (dec.mode == M_IND) begin
            pc_d = {d, plo_q};
            r.res[n[1:0]] = mk_res(1'b0, pc_d, 8'h00, 3'd5); n = n + 3'd1;
            ph_d = P_FETCH;
          end else begin
            if (dec.mode == M_INY) begin
              lo = {1'b0, plo_q} + {1'b0, g_q.y};
              pcx_d = lo[8];
              oa_d = {d, plo_q} + {8'h00, g_q.y};
            end else begin
              oa_d = {d, plo_q};
            end
            acc_en = 1'b1;
          end
        end
        P_DATA: exec_en = 1'b1;
        P_PULL1: begin
          if (opc_q == OPC_PLA) begin
            g_d.a = d;
            g_d.p = set_nz(g_q.p, d);
            r.res[n[1:0]] = mk_res(1'b0, pc_q, 8'h00, 3'd4); n = n + 3'd1;
            ph_d = P_FETCH;
          end else if (opc_q == OPC_PLP) begin
            g_d.p = d & 8'hDF;
            r.res[n[1:0]] = mk_res(1'b0, pc_q, 8'h00, 3'd4); n = n + 3'd1;
            ph_d = P_FETCH;
          end else begin
            if (opc_q == OPC_RTI) g_d.p = d & 8'hDF;
            else plo_d = d;
            g_d.sp = g_q.sp + 8'd1;
            r.res[n[1:0]] = mk_res(1'b0, {STACK_PG, g_d.sp}, 8'h00, 3'd0); n = n + 3'd1;
            ph_d = P_PULL2;
          end
        end
        P_PULL2: begin
          if (opc_q == OPC_RTI) begin
            plo_d = d;
            g_d.sp = g_q.sp + 8'd1;
            r.res[n[1:0]] = mk_res(1'b0, {STACK_PG, g_d.sp}, 8'h00, 3'd0); n = n + 3'd1;
            ph_d = P_PULL3;
          end else begin
            pc_d = {d, plo_q} + 16'd1;
            r.res[n[1:0]] = mk_res(1'b0, pc_d, 8'h00, 3'd6); n = n + 3'd1;
            ph_d = P_FETCH;
          end
        end
        P_PULL3: begin
          pc_d = {d, plo_q};
          r.res[n[1:0]] = mk_res(1'b0, pc_d, 8'h00, 3'd6); n = n + 3'd1;
          ph_d = P_FETCH;
        end
        default: ph_d = ph_q;
      endcase

      if (acc_en) begin
        if (is_store(dec.op)) begin
          r.res[n[1:0]] = mk_res(1'b1, oa_d,
                                 (dec.op == O_STA) ? g_q.a :
                                 ((dec.op == O_STX) ? g_q.x : g_q.y), 3'd0);
          n = n + 3'd1;
          r.res[n[1:0]] = mk_res(1'b0, pc_d, 8'h00, cycles_of(dec.mode, dec.op, pcx_d));
          n = n + 3'd1;
          ph_d = P_FETCH;
        end else begin
          r.res[n[1:0]] = mk_res(1'b0, oa_d, 8'h00, 3'd0); n = n + 3'd1;
          ph_d = P_DATA;
        end
      end

      if (exec_en) begin
        if (is_rmw(dec.op)) begin
          m = modify(dec.op, d, g_q.p);
          g_d.p = m.p;
          r.res[n[1:0]] = mk_res(1'b1, oa_d, m.r, 3'd0); n = n + 3'd1;
        end else begin
          g_d = alu(dec.op, d, g_q);
        end
        r.res[n[1:0]] = mk_res(1'b0, pc_d, 8'h00, cycles_of(dec.mode, dec.op, pcx_d));
        n = n + 3'd1;
        ph_d = P_FETCH;
      end
    end

    if (n != 3'd0) r.res[2'(n - 3'd1)].last = 1'b1;
    r.cnt = n;
    grp_o = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= P_IDLE;
      g_q   <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RESET, p: 8'h00};
      pc_q  <= '0;
      opc_q <= '0;
      oa_q  <= '0;
      plo_q <= '0;
      pcx_q <= 1'b0;
    end else if (beat_i) begin
      ph_q  <= ph_d;
      g_q   <= g_d;
      pc_q  <= pc_d;
      opc_q <= opc_d;
      oa_q  <= oa_d;
      plo_q <= plo_d;
      pcx_q <= pcx_d;
    end
  end

endmodule

/* design/m6502_outq.sv */
// ----------------------------------------------------------------------------
// m6502_outq
// two-entry buffer of request groups, drained one bus request per beat
// ----------------------------------------------------------------------------
module m6502_outq import m6502_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  grp_t grp_i,
  output logic ready_o,
  output logic valid_o,
  input  logic pop_i,
  output res_t res_o
);

  grp_t       slot_q [2];
  logic       head_q, tail_q;
  logic [1:0] used_q;
  logic [1:0] sub_q;
  logic       grp_end;

  assign valid_o = (used_q != 2'd0);
  assign ready_o = (used_q != 2'd2);
  assign res_o   = slot_q[head_q].res[sub_q];
  assign grp_end = ({1'b0, sub_q} == slot_q[head_q].cnt - 3'd1);

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[tail_q] <= grp_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 1'b0;
      tail_q <= 1'b0;
      used_q <= '0;
      sub_q  <= '0;
    end else begin
      if (push_i) tail_q <= ~tail_q;
      if (pop_i) begin
        if (grp_end) begin
          sub_q  <= '0;
          head_q <= ~head_q;
        end else begin
          sub_q <= sub_q + 2'd1;
        end
      end
      used_q <= used_q + {1'b0, push_i} - {1'b0, pop_i & grp_end};
    end
  end

endmodule

/* sim/tb_mos6502_instruction_core_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mos6502_instruction_core_top
// Drives returned bus bytes into the 6502 core and checks every bus request
// against an in-bench instruction-level CPU model. A directed table covers
// reset, the vector fetch and a set of special opcodes. Random opcode streams
// with random operands follow, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_mos6502_instruction_core_top;
  import m6502_pkg::*;

  localparam int N_RANDOM   = 280;
  localparam int IDLE_LIMIT = 4000;
  localparam int SHOW_MAX   = 10;

  typedef enum logic [3:0] {
    PH_IDLE, PH_VLO, PH_VHI, PH_FETCH, PH_OP1, PH_OP2, PH_PTR1, PH_PTR2,
    PH_DATA, PH_PULL1, PH_PULL2, PH_PULL3
  } cpu_phase_e;

  typedef struct {
    bit         cmd;
    logic [7:0] data;
    bit         typed;
    res_t       want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  m6502_in_if  in_ch ();
  m6502_out_if out_ch ();

  mos6502_instruction_core_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // model state
  logic [7:0]  reg_a, reg_x, reg_y, reg_sp, reg_p, reg_ir, ptr_low;
  logic [15:0] reg_pc, eff_addr;
  logic        page_crossed;
  cpu_phase_e  phase;

  res_t bus_grp [4];
  int   grp_n;
  res_t bus_expect_q [$];

  int n_fail;
  int n_shown;
  int n_checked;
  int n_instr;
  int n_beats;
  int burst_left;

  // ---------------------------------------------------------------- model

  task automatic emit(bit wr, logic [15:0] ad, logic [7:0] wd, logic [2:0] cyc);
    if (grp_n < 4) begin
      bus_grp[grp_n] = '{wr, ad, wr ? wd : 8'h00, cyc != 3'd0, cyc, 1'b0};
      grp_n++;
    end
  endtask

  task automatic fetch_op(logic [2:0] cyc);
    emit(1'b0, reg_pc, 8'h00, cyc);
    phase = PH_FETCH;
  endtask

  task automatic push_byte(logic [7:0] v);
    emit(1'b1, {STACK_PG, reg_sp}, v, 3'd0);
    reg_sp = reg_sp - 8'd1;
  endtask

  task automatic pull_byte(cpu_phase_e nph);
    reg_sp = reg_sp + 8'd1;
    emit(1'b0, {STACK_PG, reg_sp}, 8'h00, 3'd0);
    phase = nph;
  endtask

  task automatic upd_nz(logic [7:0] v);
    reg_p = (reg_p & 8'h7D) | (v & 8'h80) | ((v == 8'h00) ? F_Z : 8'h00);
  endtask

  task automatic add_acc(logic [7:0] v);
    logic [8:0] s;
    s = {1'b0, reg_a} + {1'b0, v} + {8'h00, reg_p[0]};
    reg_p = (reg_p & 8'hBE) | (s[8] ? F_C : 8'h00) |
            (((~(reg_a ^ v) & (reg_a ^ s[7:0]) & 8'h80) != 0) ? F_V : 8'h00);
    reg_a = s[7:0];
    upd_nz(reg_a);
  endtask

  task automatic compare_reg(logic [7:0] r, logic [7:0] v);
    reg_p = (reg_p & 8'hFE) | ((r >= v) ? F_C : 8'h00);
    upd_nz(r - v);
  endtask

  task automatic shift_calc(logic [4:0] o, logic [7:0] v, output logic [7:0] r);
    logic c;
    c = reg_p[0];
    case (o)
      O_ASL: begin c = v[7]; r = {v[6:0], 1'b0}; end
      O_ROL: begin r = {v[6:0], reg_p[0]}; c = v[7]; end
      O_LSR: begin c = v[0]; r = {1'b0, v[7:1]}; end
      O_ROR: begin r = {reg_p[0], v[7:1]}; c = v[0]; end
      O_DEC: r = v - 8'd1;
      default: r = v + 8'd1;
    endcase
    reg_p = {reg_p[7:1], c};
    upd_nz(r);
  endtask

  function automatic bit op_store(logic [4:0] o);
    return o == O_STA || o == O_STX || o == O_STY;
  endfunction

  function automatic bit op_rmw(logic [4:0] o);
    return (o >= O_ASL && o <= O_ROR) || o == O_DEC || o == O_INC;
  endfunction

  function automatic bit lookup(input logic [7:0] c, output logic [3:0] md,
                                output logic [4:0] o);
    logic [2:0] aaa;
    logic [2:0] bbb;
    bit xy;
    aaa = c[7:5];
    bbb = c[4:2];
    xy = (aaa == 3'd4) || (aaa == 3'd5);
    md = M_IMM;
    o = O_ORA;
    if (c == 8'h20) begin md = M_ABS; o = O_JSR; return 1; end
    if (c == 8'h4C) begin md = M_ABS; o = O_JMP; return 1; end
    if (c == 8'h6C) begin md = M_IND; o = O_JMP; return 1; end
    if (c[4:0] == 5'h10) begin md = M_REL; o = O_BR; return 1; end
    if (c[1:0] == 2'd1) begin
      if (c == 8'h89) return 0;
      o = {2'b00, aaa};
      case (bbb)
        3'd0: md = M_INX;
        3'd1: md = M_ZP;
        3'd2: md = M_IMM;
        3'd3: md = M_ABS;
        3'd4: md = M_INY;
        3'd5: md = M_ZPX;
        3'd6: md = M_ABY;
        default: md = M_ABX;
      endcase
      return 1;
    end
    if (c[1:0] == 2'd2) begin
      o = O_ASL + {2'b00, aaa};
      case (bbb)
        3'd0: begin md = M_IMM; return c == 8'hA2; end
        3'd1: begin md = M_ZP; return 1; end
        3'd3: begin md = M_ABS; return 1; end
        3'd5: begin md = xy ? M_ZPY : M_ZPX; return 1; end
        3'd7: begin md = xy ? M_ABY : M_ABX; return c != 8'h9E; end
        default: return 0;
      endcase
    end
    if (c[1:0] == 2'd0) begin
      case (c)
        8'h24: begin md = M_ZP;  o = O_BIT; end
        8'h2C: begin md = M_ABS; o = O_BIT; end
        8'h84: begin md = M_ZP;  o = O_STY; end
        8'h8C: begin md = M_ABS; o = O_STY; end
        8'h94: begin md = M_ZPX; o = O_STY; end
        8'hA0: begin md = M_IMM; o = O_LDY; end
        8'hA4: begin md = M_ZP;  o = O_LDY; end
        8'hAC: begin md = M_ABS; o = O_LDY; end
        8'hB4: begin md = M_ZPX; o = O_LDY; end
        8'hBC: begin md = M_ABX; o = O_LDY; end
        8'hC0: begin md = M_IMM; o = O_CPY; end
        8'hC4: begin md = M_ZP;  o = O_CPY; end
        8'hCC: begin md = M_ABS; o = O_CPY; end
        8'hE0: begin md = M_IMM; o = O_CPX; end
        8'hE4: begin md = M_ZP;  o = O_CPX; end
        8'hEC: begin md = M_ABS; o = O_CPX; end
        default: return 0;
      endcase
      return 1;
    end
    return 0;
  endfunction

  function automatic bit implied_code(logic [7:0] c);
    case (c)
      8'h18, 8'h38, 8'h58, 8'h78, 8'hB8, 8'hD8, 8'hF8, 8'hCA, 8'h88, 8'hE8,
      8'hC8, 8'hAA, 8'hA8, 8'hBA, 8'h8A, 8'h98, 8'h9A, 8'h0A, 8'h2A, 8'h4A,
      8'h6A, 8'hEA: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [2:0] skip_cycles(logic [7:0] c);
    case (c)
      8'h80, 8'h82, 8'h89, 8'hC2, 8'hE2: return 3'd2;
      8'h04, 8'h44, 8'h64: return 3'd3;
      8'h14, 8'h34, 8'h54, 8'h74, 8'hD4, 8'hF4: return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  function automatic bit stack_code(logic [7:0] c);
    return c == OPC_BRK || c == OPC_PHP || c == OPC_PLP || c == OPC_RTI ||
           c == OPC_PHA || c == OPC_RTS || c == OPC_PLA;
  endfunction

  function automatic logic [2:0] instr_len(logic [3:0] md, logic [4:0] o);
    logic [2:0] st [9];
    logic [2:0] rm [9];
    logic [2:0] rd [9];
    st = '{3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6};
    rm = '{3'd2, 3'd5, 3'd6, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7, 3'd7};
    rd = '{3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd6, 3'd5};
    if (md > M_INY) return 3'd2;
    if (op_store(o)) return st[md];
    if (op_rmw(o)) return rm[md];
    if (md == M_ABX || md == M_ABY || md == M_INY) return rd[md] + {2'b00, page_crossed};
    return rd[md];
  endfunction

  task automatic apply_alu(logic [4:0] o, logic [7:0] v);
    case (o)
      O_ORA: begin reg_a = reg_a | v; upd_nz(reg_a); end
      O_AND: begin reg_a = reg_a & v; upd_nz(reg_a); end
      O_EOR: begin reg_a = reg_a ^ v; upd_nz(reg_a); end
      O_ADC: add_acc(v);
      O_LDA: begin reg_a = v; upd_nz(v); end
      O_CMP: compare_reg(reg_a, v);
      O_SBC: add_acc(~v);
      O_LDX: begin reg_x = v; upd_nz(v); end
      O_LDY: begin reg_y = v; upd_nz(v); end
      O_CPY: compare_reg(reg_y, v);
      O_CPX: compare_reg(reg_x, v);
      O_BIT: reg_p = (reg_p & 8'h3D) | (v & 8'hC0) | (((reg_a & v) == 0) ? F_Z : 8'h00);
      default: ;
    endcase
  endtask

  task automatic mem_access(logic [3:0] md, logic [4:0] o);
    if (op_store(o)) begin
      emit(1'b1, eff_addr, (o == O_STA) ? reg_a : ((o == O_STX) ? reg_x : reg_y), 3'd0);
      fetch_op(instr_len(md, o));
    end else begin
      emit(1'b0, eff_addr, 8'h00, 3'd0);
      phase = PH_DATA;
    end
  endtask

  task automatic execute_op(logic [3:0] md, logic [4:0] o, logic [7:0] v);
    logic [7:0] r;
    if (op_rmw(o)) begin
      shift_calc(o, v, r);
      emit(1'b1, eff_addr, r, 3'd0);
    end else begin
      apply_alu(o, v);
    end
    fetch_op(instr_len(md, o));
  endtask

  task automatic index_base(logic [15:0] base, logic [7:0] i);
    logic [8:0] s;
    s = {1'b0, base[7:0]} + {1'b0, i};
    page_crossed = s[8];
    eff_addr = base + {8'h00, i};
  endtask

  task automatic run_implied(logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h18: reg_p = reg_p & ~F_C;
      8'h38: reg_p = reg_p | F_C;
      8'h58: reg_p = reg_p & ~F_I;
      8'h78: reg_p = reg_p | F_I;
      8'hB8: reg_p = reg_p & ~F_V;
      8'hD8: reg_p = reg_p & ~F_D;
      8'hF8: reg_p = reg_p | F_D;
      8'hCA: begin reg_x = reg_x - 8'd1; upd_nz(reg_x); end
      8'h88: begin reg_y = reg_y - 8'd1; upd_nz(reg_y); end
      8'hE8: begin reg_x = reg_x + 8'd1; upd_nz(reg_x); end
      8'hC8: begin reg_y = reg_y + 8'd1; upd_nz(reg_y); end
      8'hAA: begin reg_x = reg_a; upd_nz(reg_a); end
      8'hA8: begin reg_y = reg_a; upd_nz(reg_a); end
      8'hBA: begin reg_x = reg_sp; upd_nz(reg_sp); end
      8'h8A: begin reg_a = reg_x; upd_nz(reg_a); end
      8'h98: begin reg_a = reg_y; upd_nz(reg_a); end
      8'h9A: reg_sp = reg_x;
      8'h0A, 8'h2A, 8'h4A, 8'h6A: begin
        shift_calc(O_ASL + {2'b00, c[7:5]}, reg_a, r);
        reg_a = r;
      end
      default: ;
    endcase
  endtask

  task automatic on_opcode(logic [7:0] c);
    logic [3:0] md;
    logic [4:0] o;
    reg_ir = c;
    reg_pc = reg_pc + 16'd1;
    if (implied_code(c)) begin
      run_implied(c);
      fetch_op(3'd2);
    end else if (skip_cycles(c) != 3'd0) begin
      reg_pc = reg_pc + 16'd1;
      fetch_op(skip_cycles(c));
    end else if (c == OPC_BRK) begin
      reg_pc = reg_pc + 16'd1;
      push_byte(reg_pc[15:8]);
      push_byte(reg_pc[7:0]);
      push_byte(reg_p | 8'h30);
      reg_p = reg_p | F_I | F_B;
      eff_addr = VEC_BRK;
      emit(1'b0, eff_addr, 8'h00, 3'd0);
      phase = PH_VLO;
    end else if (c == OPC_PHA) begin
      push_byte(reg_a);
      fetch_op(3'd3);
    end else if (c == OPC_PHP) begin
      push_byte(reg_p | 8'h30);
      fetch_op(3'd3);
    end else if (c == OPC_PLA || c == OPC_PLP || c == OPC_RTS || c == OPC_RTI) begin
      pull_byte(PH_PULL1);
    end else if (lookup(c, md, o)) begin
      emit(1'b0, reg_pc, 8'h00, 3'd0);
      phase = PH_OP1;
    end else begin
      fetch_op(3'd2);
    end
  endtask

  task automatic on_operand1(logic [7:0] d);
    logic [3:0] md;
    logic [4:0] o;
    logic [7:0] msk;
    logic [15:0] t;
    logic [2:0] cyc;
    void'(lookup(reg_ir, md, o));
    reg_pc = reg_pc + 16'd1;
    case (md)
      M_IMM: execute_op(md, o, d);
      M_ZP: begin eff_addr = {8'h00, d}; mem_access(md, o); end
      M_ZPX: begin eff_addr = {8'h00, d + reg_x}; mem_access(md, o); end
      M_ZPY: begin eff_addr = {8'h00, d + reg_y}; mem_access(md, o); end
      M_INX, M_INY: begin
        eff_addr = {8'h00, (md == M_INX) ? d + reg_x : d};
        emit(1'b0, eff_addr, 8'h00, 3'd0);
        phase = PH_PTR1;
      end
      M_REL: begin
        case (reg_ir[7:6])
          2'd0: msk = 8'h80;
          2'd1: msk = F_V;
          2'd2: msk = F_C;
          default: msk = F_Z;
        endcase
        cyc = 3'd2;
        if (((reg_p & msk) != 0) == reg_ir[5]) begin
          t = reg_pc + {{8{d[7]}}, d};
          cyc = (((t ^ reg_pc) & 16'hFF00) != 0) ? 3'd4 : 3'd3;
          reg_pc = t;
        end
        fetch_op(cyc);
      end
      default: begin
        eff_addr = {8'h00, d};
        emit(1'b0, reg_pc, 8'h00, 3'd0);
        phase = PH_OP2;
      end
    endcase
  endtask

  task automatic on_operand2(logic [7:0] d);
    logic [3:0] md;
    logic [4:0] o;
    logic [15:0] base;
    logic [15:0] ret;
    void'(lookup(reg_ir, md, o));
    base = {d, eff_addr[7:0]};
    reg_pc = reg_pc + 16'd1;
    if (md == M_IND) begin
      eff_addr = base;
      emit(1'b0, base, 8'h00, 3'd0);
      phase = PH_PTR1;
    end else if (o == O_JMP) begin
      reg_pc = base;
      fetch_op(3'd3);
    end else if (o == O_JSR) begin
      ret = reg_pc - 16'd1;
      push_byte(ret[15:8]);
      push_byte(ret[7:0]);
      reg_pc = base;
      fetch_op(3'd6);
    end else begin
      if (md == M_ABX) index_base(base, reg_x);
      else if (md == M_ABY) index_base(base, reg_y);
      else eff_addr = base;
      mem_access(md, o);
    end
  endtask

  task automatic on_pointer2(logic [7:0] d);
    logic [3:0] md;
    logic [4:0] o;
    logic [15:0] base;
    void'(lookup(reg_ir, md, o));
    base = {d, ptr_low};
    if (md == M_IND) begin
      reg_pc = base;
      fetch_op(3'd5);
    end else begin
      if (md == M_INY) index_base(base, reg_y);
      else eff_addr = base;
      mem_access(md, o);
    end
  endtask

  task automatic on_stack_read(logic [7:0] d);
    case (phase)
      PH_PULL1: begin
        if (reg_ir == OPC_PLA) begin reg_a = d; upd_nz(d); fetch_op(3'd4); end
        else if (reg_ir == OPC_PLP) begin reg_p = d & 8'hDF; fetch_op(3'd4); end
        else if (reg_ir == OPC_RTI) begin reg_p = d & 8'hDF; pull_byte(PH_PULL2); end
        else begin ptr_low = d; pull_byte(PH_PULL2); end
      end
      PH_PULL2: begin
        if (reg_ir == OPC_RTI) begin ptr_low = d; pull_byte(PH_PULL3); end
        else begin reg_pc = {d, ptr_low} + 16'd1; fetch_op(3'd6); end
      end
      default: begin
        reg_pc = {d, ptr_low};
        fetch_op(3'd6);
      end
    endcase
  endtask

  // one returned byte or reset request; fills bus_grp / grp_n
  task automatic cpu_step(bit cmd, logic [7:0] d);
    logic [3:0] md;
    logic [4:0] o;
    grp_n = 0;
    if (!cmd) begin
      reg_sp = SP_RESET;
      eff_addr = VEC_RESET;
      emit(1'b0, eff_addr, 8'h00, 3'd0);
      phase = PH_VLO;
    end else begin
      case (phase)
        PH_VLO: begin
          reg_pc = {8'h00, d};
          emit(1'b0, eff_addr + 16'd1, 8'h00, 3'd0);
          phase = PH_VHI;
        end
        PH_VHI: begin
          reg_pc = {d, reg_pc[7:0]};
          fetch_op((eff_addr == VEC_BRK) ? 3'd7 : 3'd0);
        end
        PH_FETCH: on_opcode(d);
        PH_OP1: on_operand1(d);
        PH_OP2: on_operand2(d);
        PH_PTR1: begin
          ptr_low = d;
          emit(1'b0, {eff_addr[15:8], eff_addr[7:0] + 8'd1}, 8'h00, 3'd0);
          phase = PH_PTR2;
        end
        PH_PTR2: on_pointer2(d);
        PH_DATA: begin
          void'(lookup(reg_ir, md, o));
          execute_op(md, o, d);
        end
        PH_PULL1, PH_PULL2, PH_PULL3: on_stack_read(d);
        default: ;
      endcase
    end
    if (grp_n > 0) bus_grp[grp_n-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic send_beat(bit cmd, logic [7:0] d);
    int gap;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.read_data <= d;
    burst_left--;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  function automatic bit known_opcode(logic [7:0] c);
    logic [3:0] md;
    logic [4:0] o;
    return lookup(c, md, o) || implied_code(c) || skip_cycles(c) != 0 || stack_code(c);
  endfunction

  stim_row_t dir_rows [$];

  function automatic res_t rd_req(logic [15:0] ad, logic [2:0] cyc);
    return '{1'b0, ad, 8'h00, cyc != 0, cyc, 1'b1};
  endfunction

  task automatic add_row(bit cmd, logic [7:0] d);
    dir_rows.push_back('{cmd, d, 1'b0, '0});
  endtask

  initial begin
    int i;
    bit cmd;
    logic [7:0] d;
    reg_a = 0; reg_x = 0; reg_y = 0; reg_sp = SP_RESET; reg_p = 0; reg_ir = 0;
    ptr_low = 0; reg_pc = 0; eff_addr = 0; page_crossed = 0; phase = PH_IDLE;
    n_fail = 0; n_shown = 0; n_checked = 0; n_instr = 0; n_beats = 0;
    burst_left = 0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= 1'b1;
    in_ch.read_data <= 8'h00;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // data while idle, reset vector, first fetch, then special opcodes
    add_row(1'b1, 8'h00);
    dir_rows.push_back('{1'b0, 8'h00, 1'b1, rd_req(VEC_RESET, 3'd0)});
    dir_rows.push_back('{1'b1, 8'h00, 1'b1, rd_req(VEC_RESET + 16'd1, 3'd0)});
    dir_rows.push_back('{1'b1, 8'h80, 1'b1, rd_req(16'h8000, 3'd0)});
    dir_rows.push_back('{1'b1, 8'hEA, 1'b1, rd_req(16'h8001, 3'd2)});
    add_row(1'b1, 8'hA9); add_row(1'b1, 8'hFF);
    add_row(1'b1, 8'h0A);
    add_row(1'b1, 8'h69); add_row(1'b1, 8'h7F);
    add_row(1'b1, 8'hE9); add_row(1'b1, 8'h80);
    add_row(1'b1, 8'h02);
    add_row(1'b1, 8'h14);
    add_row(1'b1, 8'h08);
    add_row(1'b1, 8'h28);
    add_row(1'b1, 8'h9D); add_row(1'b1, 8'hFF); add_row(1'b1, 8'h12);
    add_row(1'b1, 8'h6C); add_row(1'b1, 8'hFF); add_row(1'b1, 8'h12);
    add_row(1'b1, 8'h34); add_row(1'b1, 8'h56);
    add_row(1'b1, 8'h00); add_row(1'b1, 8'h00); add_row(1'b1, 8'h90);

    foreach (dir_rows[k]) begin
      send_beat(dir_rows[k].cmd, dir_rows[k].data);
      cpu_step(dir_rows[k].cmd, dir_rows[k].data);
      if (dir_rows[k].typed) bus_expect_q.push_back(dir_rows[k].want);
      else for (i = 0; i < grp_n; i++) bus_expect_q.push_back(bus_grp[i]);
      if (grp_n > 0) n_beats++;
    end

    i = 0;
    while (i < N_RANDOM) begin
      cmd = 1'b1;
      d = 8'($urandom);
      if (phase == PH_IDLE) begin
        cmd = ($urandom_range(0, 3) == 0);
      end else if ($urandom_range(0, 99) < 2) begin
        cmd = 1'b0;
      end else if (phase == PH_FETCH && $urandom_range(0, 99) < 85) begin
        do d = 8'($urandom); while (!known_opcode(d));
      end
      send_beat(cmd, d);
      cpu_step(cmd, d);
      for (int k = 0; k < grp_n; k++) bus_expect_q.push_back(bus_grp[k]);
      if (grp_n > 0) begin
        n_beats++;
        i++;
      end
    end
    in_ch.valid <= 1'b0;

    while (bus_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (bus_expect_q.size() != 0) n_fail++;
    $display("drove %0d input beats, checked %0d bus requests over %0d completed instructions",
             n_beats, n_checked, n_instr);
    $display("%0d mismatches", n_fail);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  initial begin
    int mode;
    int left;
    out_ch.ready <= 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(8, 40);
      end
      left--;
      case (mode)
        0: out_ch.ready <= rst_ni;
        1: out_ch.ready <= rst_ni && ($urandom_range(0, 9) < 7);
        default: out_ch.ready <= rst_ni && ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (out_ch.valid && out_ch.ready) begin
      got = '{out_ch.bus_write, out_ch.bus_addr, out_ch.bus_wdata, out_ch.instr_done,
              out_ch.instr_cycles, out_ch.last};
      if (bus_expect_q.size() == 0) begin
        n_fail++;
        if (n_shown < SHOW_MAX) begin
          n_shown++;
          $display("unexpected bus request wr=%0b addr=%h wd=%h", got.bus_write,
                   got.bus_addr, got.bus_wdata);
        end
      end else begin
        want = bus_expect_q.pop_front();
        n_checked++;
        if (want.instr_done) n_instr++;
        if (got.bus_write !== want.bus_write || got.bus_addr !== want.bus_addr ||
            got.bus_wdata !== want.bus_wdata || got.instr_done !== want.instr_done ||
            got.instr_cycles !== want.instr_cycles || got.last !== want.last) begin
          n_fail++;
          if (n_shown < SHOW_MAX) begin
            n_shown++;
            $display("mismatch exp wr=%0b addr=%h wd=%h done=%0b cyc=%0d last=%0b",
                     want.bus_write, want.bus_addr, want.bus_wdata, want.instr_done,
                     want.instr_cycles, want.last);
            $display("         got wr=%0b addr=%h wd=%h done=%0b cyc=%0d last=%0b",
                     got.bus_write, got.bus_addr, got.bus_wdata, got.instr_done,
                     got.instr_cycles, got.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

endmodule
